// File: design/bmp2rgb_pkg.sv
// Shared widths, register indexes and reset values for the BMP24 to RGB565 pixel writer.
// Used by the top level and by its port checker; depends on nothing else.
package bmp2rgb_pkg;

    localparam int MAX_DIM_DEFAULT = 2048;

    localparam int BYTE_W     = 8;
    localparam int DIM_W      = 12;
    localparam int POS_W      = 11;
    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_DEST_X        = 3'd2,
        CFG_DEST_Y        = 3'd3,
        CFG_CANVAS_WIDTH  = 3'd4,
        CFG_CANVAS_HEIGHT = 3'd5,
        CFG_KEY_COLOR     = 3'd6,
        CFG_KEY_ENABLE    = 3'd7
    } cfg_reg_t;

    localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST   = 12'd1;
    localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST  = 12'd1;
    localparam logic [POS_W-1:0]   DEST_X_RST        = 11'd0;
    localparam logic [POS_W-1:0]   DEST_Y_RST        = 11'd0;
    localparam logic [DIM_W-1:0]   CANVAS_WIDTH_RST  = 12'd1024;
    localparam logic [DIM_W-1:0]   CANVAS_HEIGHT_RST = 12'd768;
    localparam logic [COLOR_W-1:0] KEY_COLOR_RST     = 16'd0;

endpackage

// File: design/bmp24_to_rgb565_pixel_writer.sv
// Channel  | dir | tdata / tuser / tlast
// s_       | in  | tdata[7:0] data_byte
// m_       | out | tdata[21:0] pixel_address, [37:22] pixel_color, [39:38] zero;
//          |     | tuser write_pixel; tlast image_done
// One byte per cycle in while ready; a red byte gives a result two registers later (pixel
// register, then result register holding address multiply and clip compare). Blue, green
// and padding bytes give no result. Reset clears counters and both valid bits and reloads
// the register file; the stream restarts on a write of image_width or image_height.
// s_tready falls only when both the pixel register and a stalled result register are full.
// Depends on bmp2rgb_pkg.
module bmp24_to_rgb565_pixel_writer #(
    parameter int MAX_DIM = bmp2rgb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bmp2rgb_pkg::BYTE_W-1:0]        s_tdata,     // [7:0] data_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bmp2rgb_pkg::OUT_DATA_W-1:0]    m_tdata,     // [21:0] pixel_address,
                                                               // [37:22] pixel_color
    output logic                                  m_tuser,     // [0] write_pixel
    output logic                                  m_tlast,     // image_done
    input  logic                                  cfg_wen,
    input  logic [bmp2rgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmp2rgb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bmp2rgb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int EFF_W  = $clog2(MAX_DIM + 1);
    localparam int XW     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int PROD_W = XW + DIM_W;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_PAD   = 2'd3
    } phase_t;

    function automatic logic [EFF_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [EFF_W-1:0] r;
        if (v == '0) begin
            r = EFF_W'(1);
        end else if ({1'b0, v} > (DIM_W+1)'(MAX_DIM)) begin
            r = EFF_W'(MAX_DIM);
        end else begin
            r = EFF_W'(v);
        end
        return r;
    endfunction

    logic [DIM_W-1:0]   image_width_reg, image_height_reg, canvas_width_reg, canvas_height_reg;
    logic [POS_W-1:0]   dest_x_reg, dest_y_reg;
    logic [COLOR_W-1:0] key_color_reg;
    logic               key_enable_reg;

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  blue_reg, blue_next, green_reg, green_next;
    logic [CNT_W-1:0]   column_reg, column_next, row_reg, row_next;
    logic [1:0]         pad_reg, pad_next;

    logic               a_valid_reg, a_valid_next;
    logic [COLOR_W-1:0] a_color_reg;
    logic [XW-1:0]      a_cx_reg, a_cy_reg;
    logic               a_last_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_write_reg, out_last_reg;

    logic               out_free, accept, load_a, restart;
    logic [EFF_W-1:0]   w_eff, h_eff, h_restart;
    logic               col_wrap, pix_last;
    logic [COLOR_W-1:0] pix_color;
    logic [XW-1:0]      pix_cx, pix_cy;
    logic [PROD_W-1:0]  row_base;
    logic [PROD_W:0]    addr_full;
    logic               on_canvas, keyed;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign restart  = cfg_wen && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);
    assign load_a   = accept && phase_reg == PH_RED;

    assign w_eff     = clamp_dim(image_width_reg);
    assign h_eff     = clamp_dim(image_height_reg);
    assign h_restart = (cfg_index == CFG_IMAGE_HEIGHT) ? clamp_dim(cfg_wdata[DIM_W-1:0]) : h_eff;

    assign col_wrap  = (EFF_W'(column_reg) + EFF_W'(1)) >= w_eff;
    assign pix_last  = (row_reg == '0) && col_wrap;
    assign pix_color = {s_tdata[7:3], green_reg[7:2], blue_reg[7:3]};
    assign pix_cx    = XW'(dest_x_reg) + XW'(column_reg);
    assign pix_cy    = XW'(dest_y_reg) + XW'(row_reg);

    always_comb begin
        phase_next   = phase_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        pad_next     = pad_reg;
        a_valid_next = a_valid_reg && !out_free;
        if (accept) begin
            unique case (phase_reg)
                PH_BLUE: begin
                    blue_next  = s_tdata;
                    phase_next = PH_GREEN;
                end
                PH_GREEN: begin
                    green_next = s_tdata;
                    phase_next = PH_RED;
                end
                PH_RED: begin
                    a_valid_next = 1'b1;
                    phase_next   = PH_BLUE;
                    if (col_wrap) begin
                        column_next = '0;
                        if (pix_last) begin
                            row_next = CNT_W'(h_eff - EFF_W'(1));
                        end else begin
                            row_next = row_reg - CNT_W'(1);
                        end
                        // (-3w) mod 4 equals w mod 4
                        if (w_eff[1:0] != 2'd0) begin
                            pad_next   = w_eff[1:0];
                            phase_next = PH_PAD;
                        end
                    end else begin
                        column_next = column_reg + CNT_W'(1);
                    end
                end
                PH_PAD: begin
                    if (pad_reg != 2'd0) begin
                        pad_next = pad_reg - 2'd1;
                    end
                    if (pad_reg <= 2'd1) begin
                        phase_next = PH_BLUE;
                    end
                end
                default: phase_next = PH_BLUE;
            endcase
        end
        if (restart) begin
            phase_next  = PH_BLUE;
            blue_next   = '0;
            green_next  = '0;
            column_next = '0;
            pad_next    = '0;
            row_next    = CNT_W'(h_restart - EFF_W'(1));
        end
    end

    assign row_base  = PROD_W'(a_cy_reg) * PROD_W'(canvas_width_reg);
    assign addr_full = (PROD_W+1)'(row_base) + (PROD_W+1)'(a_cx_reg);
    assign on_canvas = (a_cx_reg < XW'(canvas_width_reg)) && (a_cy_reg < XW'(canvas_height_reg));
    assign keyed     = key_enable_reg && (a_color_reg == key_color_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= IMAGE_WIDTH_RST;
            image_height_reg  <= IMAGE_HEIGHT_RST;
            dest_x_reg        <= DEST_X_RST;
            dest_y_reg        <= DEST_Y_RST;
            canvas_width_reg  <= CANVAS_WIDTH_RST;
            canvas_height_reg <= CANVAS_HEIGHT_RST;
            key_color_reg     <= KEY_COLOR_RST;
            key_enable_reg    <= 1'b0;
            phase_reg         <= PH_BLUE;
            blue_reg          <= '0;
            green_reg         <= '0;
            column_reg        <= '0;
            row_reg           <= CNT_W'(clamp_dim(IMAGE_HEIGHT_RST) - EFF_W'(1));
            pad_reg           <= '0;
            a_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata[DIM_W-1:0];
                    CFG_DEST_X:        dest_x_reg        <= cfg_wdata[POS_W-1:0];
                    CFG_DEST_Y:        dest_y_reg        <= cfg_wdata[POS_W-1:0];
                    CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_wdata[DIM_W-1:0];
                    CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_wdata[DIM_W-1:0];
                    CFG_KEY_COLOR:     key_color_reg     <= cfg_wdata[COLOR_W-1:0];
                    CFG_KEY_ENABLE:    key_enable_reg    <= cfg_wdata[0];
                    default:           key_enable_reg    <= key_enable_reg;
                endcase
            end
            phase_reg   <= phase_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
            a_valid_reg <= a_valid_next;
            if (load_a) begin
                a_color_reg <= pix_color;
                a_cx_reg    <= pix_cx;
                a_cy_reg    <= pix_cy;
                a_last_reg  <= pix_last;
            end
            if (out_free) begin
                out_valid_reg <= a_valid_reg;
            end
            if (out_free && a_valid_reg) begin
                out_addr_reg  <= addr_full[ADDR_W-1:0];
                out_color_reg <= a_color_reg;
                out_write_reg <= on_canvas && !keyed;
                out_last_reg  <= a_last_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W-ADDR_W-COLOR_W)'(0), out_color_reg, out_addr_reg};
    assign m_tuser  = out_write_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: design/bmp2rgb_checker.sv
// Port-level checker for the BMP24 to RGB565 pixel writer, bound to the top level.
// Depends on bmp2rgb_pkg and sees the top level's ports only.
module bmp2rgb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bmp2rgb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                                m_tuser,
    input logic                                m_tlast
);
    import bmp2rgb_pkg::*;

    localparam int FILL_W = OUT_DATA_W - ADDR_W - COLOR_W;

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped under stall");

    a_stall_holds_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed under stall");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1 -: FILL_W] == '0)
        else $error("tdata fill bits not zero");

endmodule

bind bmp24_to_rgb565_pixel_writer bmp2rgb_checker u_bmp2rgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/bmp24_to_rgb565_pixel_writer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bmp24_to_rgb565_pixel_writer: streams BMP24 pixel bytes with
// random gaps and output stalls, predicts every canvas write and compares each transaction.
// Depends on bmp2rgb_pkg and the pixel writer RTL.
module bmp24_to_rgb565_pixel_writer_tb;
    import bmp2rgb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int BYTE_TARGET = 1750;
    localparam int CALM_AFTER  = 1500;

    typedef enum logic [1:0] {
        EXP_BLUE  = 2'd0,
        EXP_GREEN = 2'd1,
        EXP_RED   = 2'd2,
        EXP_PAD   = 2'd3
    } byte_slot_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               wr;
        logic               done;
    } pixel_write_t;

    class canvas_write_model;
        logic [DIM_W-1:0]   img_w, img_h, canvas_w, canvas_h;
        logic [POS_W-1:0]   dst_x, dst_y;
        logic [COLOR_W-1:0] key;
        logic               key_on;
        byte_slot_t         slot;
        logic [7:0]         blue, green;
        int unsigned        col, row, pad_left;
        pixel_write_t       pending[$];
        int                 errors;

        function new();
            img_w    = IMAGE_WIDTH_RST;
            img_h    = IMAGE_HEIGHT_RST;
            dst_x    = DEST_X_RST;
            dst_y    = DEST_Y_RST;
            canvas_w = CANVAS_WIDTH_RST;
            canvas_h = CANVAS_HEIGHT_RST;
            key      = KEY_COLOR_RST;
            key_on   = 1'b0;
            errors   = 0;
            restart();
        endfunction

        function int unsigned eff_dim(int unsigned v);
            if (v == 0) return 1;
            if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
            return v;
        endfunction

        function void restart();
            slot     = EXP_BLUE;
            blue     = '0;
            green    = '0;
            col      = 0;
            pad_left = 0;
            row      = eff_dim(32'(img_h)) - 1;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_IMAGE_WIDTH: begin
                    img_w = v[DIM_W-1:0];
                    restart();
                end
                CFG_IMAGE_HEIGHT: begin
                    img_h = v[DIM_W-1:0];
                    restart();
                end
                CFG_DEST_X:        dst_x    = v[POS_W-1:0];
                CFG_DEST_Y:        dst_y    = v[POS_W-1:0];
                CFG_CANVAS_WIDTH:  canvas_w = v[DIM_W-1:0];
                CFG_CANVAS_HEIGHT: canvas_h = v[DIM_W-1:0];
                CFG_KEY_COLOR:     key      = v[COLOR_W-1:0];
                CFG_KEY_ENABLE:    key_on   = v[0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned  w, h, cx, cy, prod, pad;
            pixel_write_t exp;
            case (slot)
                EXP_BLUE: begin
                    blue = b;
                    slot = EXP_GREEN;
                end
                EXP_GREEN: begin
                    green = b;
                    slot  = EXP_RED;
                end
                EXP_PAD: begin
                    if (pad_left > 0) pad_left--;
                    if (pad_left == 0) slot = EXP_BLUE;
                end
                default: begin
                    w         = eff_dim(32'(img_w));
                    h         = eff_dim(32'(img_h));
                    exp.color = {b[7:3], green[7:2], blue[7:3]};
                    cx        = 32'(dst_x) + col;
                    cy        = 32'(dst_y) + row;
                    prod      = cy * 32'(canvas_w) + cx;
                    exp.addr  = prod[ADDR_W-1:0];
                    exp.wr    = (cx < 32'(canvas_w)) && (cy < 32'(canvas_h)) &&
                                !(key_on && exp.color == key);
                    exp.done  = (row == 0) && (col + 1 >= w);
                    pending.push_back(exp);
                    slot = EXP_BLUE;
                    if (col + 1 >= w) begin
                        col = 0;
                        if (exp.done) row = h - 1;
                        else if (row > 0) row--;
                        pad = (4 - ((3 * w) % 4)) % 4;
                        if (pad != 0) begin
                            pad_left = pad;
                            slot     = EXP_PAD;
                        end
                    end else begin
                        col++;
                    end
                end
            endcase
        endfunction

        function void check_write(pixel_write_t got);
            pixel_write_t exp;
            if (pending.size() == 0) begin
                if (errors < 10)
                    $display("unexpected write: addr %0d color %h wr %b done %b",
                             got.addr, got.color, got.wr, got.done);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                if (errors < 10) begin
                    $write("write mismatch: exp addr %0d color %h wr %b done %b, ",
                           exp.addr, exp.color, exp.wr, exp.done);
                    $display("got addr %0d color %h wr %b done %b",
                             got.addr, got.color, got.wr, got.done);
                end
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    canvas_write_model     canvas_writes;
    int                    cycles     = 0;
    int                    stall_left = 0;
    int                    bytes_sent = 0;
    int                    bytes_left = 0;
    bit                    idling     = 1'b1;
    logic [COLOR_W-1:0]    cur_key    = '0;
    logic                  cur_ken    = 1'b0;

    bmp24_to_rgb565_pixel_writer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) canvas_writes.take_byte(s_tdata);
            if (m_tvalid && m_tready)
                canvas_writes.check_write({m_tdata[21:0], m_tdata[37:22], m_tuser, m_tlast});
        end
    end

    // hold m_tready low in short random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (bytes_left == 0) return;
        if (idling && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        bytes_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (canvas_writes.pending.size() != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        canvas_writes.write_reg(idx, val);
    endtask

    task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] dx, logic [15:0] dy,
                             logic [15:0] cw, logic [15:0] ch, logic [15:0] key,
                             logic [15:0] ken);
        set_reg(CFG_DEST_X, dx);
        set_reg(CFG_DEST_Y, dy);
        set_reg(CFG_CANVAS_WIDTH, cw);
        set_reg(CFG_CANVAS_HEIGHT, ch);
        set_reg(CFG_KEY_COLOR, key);
        set_reg(CFG_KEY_ENABLE, ken);
        set_reg(CFG_IMAGE_WIDTH, w);
        set_reg(CFG_IMAGE_HEIGHT, h);
        cfg_wen <= 1'b0;
        cur_key = key;
        cur_ken = ken[0];
    endtask

    // bytes in stream order: blue, green, red; often hit the key color when keying is on
    function automatic logic [23:0] pick_pixel();
        logic [23:0] px;
        px = 24'($urandom);
        if (cur_ken && $urandom_range(0, 2) == 0) begin
            px[7:3]   = cur_key[4:0];
            px[15:10] = cur_key[10:5];
            px[23:19] = cur_key[15:11];
        end
        return px;
    endfunction

    task automatic send_image(int unsigned w, int unsigned h);
        int unsigned pad;
        logic [23:0] px;
        pad = (4 - ((3 * w) % 4)) % 4;
        for (int unsigned r = 0; r < h && bytes_left > 0; r++) begin
            for (int unsigned c = 0; c < w && bytes_left > 0; c++) begin
                px = pick_pixel();
                send_byte(px[7:0]);
                send_byte(px[15:8]);
                send_byte(px[23:16]);
            end
            repeat (pad) send_byte(8'($urandom));
        end
    endtask

    function automatic int unsigned pick_dim(int unsigned typical);
        case ($urandom_range(0, 19))
            0:       return 2048;
            1:       return $urandom_range(1, 2048);
            2:       return 1;
            default: return $urandom_range(1, typical);
        endcase
    endfunction

    function automatic int unsigned pick_pos();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2047;
            2:       return $urandom_range(0, 2047);
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    function automatic int unsigned pick_canvas();
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return 2048;
            2:       return $urandom_range(1, 2048);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial begin
        int unsigned w, h, full;
        canvas_writes = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one-pixel image with one padding byte per row
        bytes_left = 8;
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
        drain();

        // zero width, address wrap, off-canvas row, keyed white pixels
        configure(16'd0, 16'd2, 16'd2047, 16'd2047, 16'd2048, 16'd2048, 16'hFFFF, 16'd1);
        bytes_left = 8;
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hAA);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h55);
        drain();

        // oversized dimensions clamp; one-pixel canvas
        configure(16'd4095, 16'd4095, 16'd0, 16'd0, 16'd1, 16'd1, 16'h0000, 16'd0);
        bytes_left = 6;
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);

        while (bytes_sent < BYTE_TARGET) begin
            drain();
            idling = (bytes_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            configure(16'(pick_dim(7)), 16'(pick_dim(4)), 16'(pick_pos()), 16'(pick_pos()),
                      16'(pick_canvas()), 16'(pick_canvas()), 16'($urandom),
                      16'($urandom_range(0, 1)));
            w    = canvas_writes.eff_dim(32'(canvas_writes.img_w));
            h    = canvas_writes.eff_dim(32'(canvas_writes.img_h));
            full = (3 * w + (4 - ((3 * w) % 4)) % 4) * h;
            if (full > 400) bytes_left = $urandom_range(10, 300);
            else bytes_left = full * $urandom_range(1, 2) + $urandom_range(0, 4);
            while (bytes_left > 0) send_image(w, h);
        end

        drain();
        if (canvas_writes.errors == 0 && canvas_writes.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
